@@ rtl/waterfall_row_ring_bilinear_sampler_unit_assert.svh @@
// Assertion macros for the waterfall sampler RTL.
// Needs clk and rst_n in the including scope.
`ifndef WATERFALL_ROW_RING_BILINEAR_SAMPLER_UNIT_ASSERT_SVH
`define WATERFALL_ROW_RING_BILINEAR_SAMPLER_UNIT_ASSERT_SVH

// invariant checked on every clock out of reset
`define WRBS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("wrbs invariant violated");

// implication checked on every clock out of reset
`define WRBS_ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("wrbs sequence violated");

`endif

@@ rtl/wrbs_pkg.sv @@
// Shared types and codes for the waterfall row ring sampler.
// No dependencies.
package wrbs_pkg;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [3:0] CFG_MAX_ROWS  = 4'd0;
  localparam logic [3:0] CFG_ANTIALIAS = 4'd1;
  localparam logic [3:0] CFG_X_MIN     = 4'd2;
  localparam logic [3:0] CFG_X_RANGE   = 4'd3;

  localparam logic [15:0] EMPTY_LEVEL = 16'h8000;
  localparam int LEN_W = 11;

  typedef struct packed {
    logic [1:0]       op;
    logic [15:0]      sample;
    logic [LEN_W-1:0] len;
    logic             row_end;
    logic [31:0]      x_pos;
    logic [15:0]      y_pos;
  } item_t;

  typedef struct packed {
    logic [8:0]  max_rows;
    logic        antialias;
    logic [31:0] x_min;
    logic [31:0] x_range;
    logic        clr;
  } cfg_t;

endpackage

@@ rtl/waterfall_row_ring_bilinear_sampler_unit.sv @@
// Top level of the waterfall row ring sampler: config registers, front, queue, back.
// Depends on wrbs_pkg, wrbs_front, wrbs_queue, wrbs_back.
//
//  channel | handshake              | payload
//  in      | in_push / in_full      | func, sample, row_len, row_end, x_pos, y_pos
//  out     | out_pop / out_empty    | level, level_valid
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Append: a short row's row_end pads its missing bins with EMPTY_LEVEL in S_FILL.
// Query: the bit-serial divider produces the bin quotient, then the nearest tap or
// four blended taps are read (one store read port).
// Reset is synchronous; the store itself is never cleared, row counts are.
// A two-entry queue decouples input from the back end; a result register lets
// the back end take the next item while the last result waits for out_pop.
module waterfall_row_ring_bilinear_sampler_unit #(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_BINS  = 1024,
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_sample,
  input  logic [10:0]        in_row_len,
  input  logic               in_row_end,
  input  logic [31:0]        in_x_pos,
  input  logic [15:0]        in_y_pos,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [15:0] out_level,
  output logic               out_level_valid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import wrbs_pkg::*;

  localparam logic [8:0] ROWS_RST = 9'((MAX_ROWS < 256) ? MAX_ROWS : 256);

  logic [8:0]  max_rows_r;
  logic        antialias_r;
  logic [31:0] x_min_r, x_range_r;
  logic [8:0]  rows_clamped;
  cfg_t        cfg;

  item_t q_in, q_out;
  logic  q_push, q_full, q_pop, q_empty;
  logic [15:0] level_u;

  // cfg_ready is always high; config must only be written while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_comb begin
    rows_clamped = cfg_data[8:0];
    if (cfg_data[8:0] == '0) rows_clamped = 9'd1;
    else if (32'(cfg_data[8:0]) > MAX_ROWS) rows_clamped = 9'(MAX_ROWS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rows_r  <= ROWS_RST;
      antialias_r <= 1'b1;
      x_min_r     <= '0;
      x_range_r   <= 32'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_ROWS:  max_rows_r  <= rows_clamped;
        CFG_ANTIALIAS: antialias_r <= cfg_data[0];
        CFG_X_MIN:     x_min_r     <= cfg_data;
        CFG_X_RANGE:   x_range_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // writing max_rows empties the ring in the back end
  assign cfg.max_rows  = max_rows_r;
  assign cfg.antialias = antialias_r;
  assign cfg.x_min     = x_min_r;
  assign cfg.x_range   = x_range_r;
  assign cfg.clr       = cfg_valid && (cfg_index == CFG_MAX_ROWS);

  wrbs_front #(.MAX_BINS(MAX_BINS)) u_front (
    .push(in_push), .full(in_full), .func(in_func), .sample(in_sample),
    .row_len(in_row_len), .row_end(in_row_end), .x_pos(in_x_pos), .y_pos(in_y_pos),
    .q_push(q_push), .q_item(q_in), .q_full(q_full)
  );

  wrbs_queue #(.DEPTH(2)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(q_in), .full(q_full),
    .pop(q_pop), .dout(q_out), .empty(q_empty)
  );

  wrbs_back #(.MAX_ROWS(MAX_ROWS), .MAX_BINS(MAX_BINS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .q_item(q_out), .q_empty(q_empty),
    .q_pop(q_pop), .out_empty(out_empty), .out_pop(out_pop),
    .out_level(level_u), .out_level_valid(out_level_valid)
  );

  assign out_level = $signed(level_u);
endmodule

@@ rtl/wrbs_front.sv @@
// Front end: decodes func, clamps row length, drops OP_NONE items.
// Depends on wrbs_pkg.
module wrbs_front #(
  parameter int MAX_BINS = 1024
) (
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           func,
  input  logic [15:0]          sample,
  input  logic [10:0]          row_len,
  input  logic                 row_end,
  input  logic [31:0]          x_pos,
  input  logic [15:0]          y_pos,
  output logic                 q_push,
  output wrbs_pkg::item_t      q_item,
  input  logic                 q_full
);
  import wrbs_pkg::*;

  assign full   = q_full;
  assign q_push = push && !q_full && (func != OP_NONE);

  always_comb begin
    q_item.op      = func;
    q_item.sample  = sample;
    q_item.len     = (32'(row_len) > MAX_BINS) ? LEN_W'(MAX_BINS) : row_len;
    q_item.row_end = row_end;
    q_item.x_pos   = x_pos;
    q_item.y_pos   = y_pos;
  end
endmodule

@@ rtl/wrbs_queue.sv @@
// Short item queue between front and back end.
// Depends on wrbs_pkg.
module wrbs_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wrbs_pkg::item_t din,
  output logic            full,
  input  logic            pop,
  output wrbs_pkg::item_t dout,
  output logic            empty
);
  import wrbs_pkg::*;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t        mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop && !empty) rp_r <= (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= din;
  end
endmodule

@@ rtl/wrbs_back.sv @@
// Back end: row ring store, append sequencer, query divider and blend.
// Depends on wrbs_pkg and the assertion macro header.
`include "waterfall_row_ring_bilinear_sampler_unit_assert.svh"
module wrbs_back #(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_BINS  = 1024,
  parameter int FRAC_BITS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  wrbs_pkg::cfg_t  cfg,
  input  wrbs_pkg::item_t q_item,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [15:0]     out_level,
  output logic            out_level_valid
);
  import wrbs_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int BW   = $clog2(MAX_BINS);
  localparam int AW   = RW + BW;
  localparam int YQW  = 8 + F;
  localparam int TW   = 9 + F;
  localparam int NUMW = 32 + LEN_W + F;
  localparam int CW   = $clog2(NUMW);
  localparam int WW   = 2*F + 2;
  localparam int PRW  = WW + 17;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FILL = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_TAPA = 4'd5;
  localparam logic [3:0] S_TAPB = 4'd6;
  localparam logic [3:0] S_TAPC = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam logic [F:0] ONE = (F+1)'(1) << F;

  logic [15:0] mem [MAX_ROWS << BW];

  logic [3:0]       st_r, st_nxt;
  logic [RW-1:0]    head_r, head_nxt;
  logic [8:0]       held_r, held_nxt;
  logic [LEN_W-1:0] bins_r, bins_nxt;
  logic [LEN_W-1:0] wb_r, wb_nxt;
  logic             open_r, open_nxt;
  logic             outv_r, outv_nxt;
  logic [15:0]      olev_r, olev_nxt;
  logic             olv_r, olv_nxt;

  logic [TW-1:0]    rowq_r, rowq_nxt;
  logic [31:0]      diff_r, diff_nxt;
  logic [NUMW-1:0]  num_r, num_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [8:0]       r0_r, r0_nxt, r1_r, r1_nxt;
  logic [LEN_W-1:0] b0_r, b0_nxt, b1_r, b1_nxt;
  logic [F-1:0]     tx_r, tx_nxt, ty_r, ty_nxt;
  logic [9:0]       base_r, base_nxt;
  logic [1:0]       tap_r, tap_nxt;
  logic [WW-1:0]    w_r, w_nxt;
  logic [PRW-1:0]   prod_r, prod_nxt;
  logic [PRW-1:0]   acc_r, acc_nxt;
  logic             emp_r, emp_nxt;
  logic [15:0]      res_r, res_nxt;
  logic             resv_r, resv_nxt;
  logic [15:0]      rdata_r;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [15:0]      wdata;

  // append scratch
  logic             a_new;
  logic [LEN_W-1:0] a_bins, a_wb, a_wb2;
  logic [RW-1:0]    a_head;
  logic [8:0]       a_held0, a_held;
  logic             a_wr;
  // query scratch
  logic [YQW-1:0]   yq;
  logic [TW-1:0]    top;
  logic [32:0]      dt;
  logic [NUMW-1:0]  binq;
  logic [9:0]       slot, b10;
  logic [8:0]       ry;
  logic [LEN_W-1:0] bx;
  logic [F:0]       wy, wx;
  logic [PRW-1:0]   rnd;

  assign q_pop           = (st_r == S_IDLE) && !q_empty && !cfg.clr;
  assign out_empty       = !outv_r;
  assign out_level       = olev_r;
  assign out_level_valid = olv_r;

  always_comb begin
    st_nxt = st_r;      head_nxt = head_r;  held_nxt = held_r;
    bins_nxt = bins_r;  wb_nxt = wb_r;      open_nxt = open_r;
    outv_nxt = outv_r;  olev_nxt = olev_r;  olv_nxt = olv_r;
    rowq_nxt = rowq_r;  diff_nxt = diff_r;  num_nxt = num_r;
    rem_nxt = rem_r;    cnt_nxt = cnt_r;    r0_nxt = r0_r;  r1_nxt = r1_r;
    b0_nxt = b0_r;      b1_nxt = b1_r;      tx_nxt = tx_r;  ty_nxt = ty_r;
    base_nxt = base_r;  tap_nxt = tap_r;    w_nxt = w_r;    prod_nxt = prod_r;
    acc_nxt = acc_r;    emp_nxt = emp_r;    res_nxt = res_r; resv_nxt = resv_r;
    we = 1'b0; re = 1'b0; waddr = '0; raddr = '0; wdata = q_item.sample;

    a_new   = !open_r && (q_item.len != bins_r);
    a_bins  = a_new ? q_item.len : bins_r;
    a_head  = a_new ? '0 : head_r;
    a_held0 = a_new ? '0 : held_r;
    a_held  = (!open_r && a_held0 >= cfg.max_rows) ? cfg.max_rows - 9'd1 : a_held0;
    a_wb    = open_r ? wb_r : '0;
    a_wr    = a_wb < a_bins;
    a_wb2   = a_wb + LEN_W'(a_wr);

    yq   = YQW'((32'(q_item.y_pos) << F) >> 8);
    top  = {held_r - 9'd1, {F{1'b0}}};
    dt   = {rem_r, num_r[NUMW-1]} - {1'b0, cfg.x_range};
    binq = num_r;
    b10  = 10'(head_r) + 10'(cfg.max_rows) - 10'(held_r);
    ry   = tap_r[1] ? r1_r : r0_r;
    bx   = tap_r[0] ? b1_r : b0_r;
    slot = base_r + 10'(ry);
    if (slot >= 10'(cfg.max_rows)) slot = slot - 10'(cfg.max_rows);
    wy   = tap_r[1] ? (F+1)'(ty_r) : ONE - (F+1)'(ty_r);
    wx   = tap_r[0] ? (F+1)'(tx_r) : ONE - (F+1)'(tx_r);
    rnd  = acc_r + (PRW'(1) << (2*F - 1));

    if (outv_r && out_pop) outv_nxt = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (q_pop) begin
          case (q_item.op)
            OP_APPEND: begin
              if (!(!open_r && q_item.len == '0)) begin
                bins_nxt = a_bins; head_nxt = a_head; held_nxt = a_held;
                open_nxt = 1'b1;
                we    = a_wr;
                waddr = {a_head, BW'(a_wb)};
                wb_nxt = a_wb2;
                if (q_item.row_end) begin
                  if (a_wb2 < a_bins) begin
                    st_nxt = S_FILL;
                  end else begin
                    head_nxt = (10'(a_head) + 10'd1 == 10'(cfg.max_rows)) ? '0 : a_head + 1'b1;
                    held_nxt = (a_held < cfg.max_rows) ? a_held + 9'd1 : a_held;
                    open_nxt = 1'b0;
                    wb_nxt   = '0;
                  end
                end
              end
            end
            OP_QUERY: begin
              rowq_nxt = top - TW'(yq);
              diff_nxt = q_item.x_pos - cfg.x_min;
              if (held_r == '0 || bins_r == '0 || cfg.x_range == '0 ||
                  TW'(yq) > top || q_item.x_pos < cfg.x_min) begin
                res_nxt = EMPTY_LEVEL; resv_nxt = 1'b0; st_nxt = S_DONE;
              end else begin
                st_nxt = S_MUL;
              end
            end
            OP_CLEAR: begin
              head_nxt = '0; held_nxt = '0; wb_nxt = '0; open_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        we = 1'b1; waddr = {head_r, BW'(wb_r)}; wdata = EMPTY_LEVEL;
        wb_nxt = wb_r + 1'b1;
        if (wb_r + 1'b1 == bins_r) begin
          head_nxt = (10'(head_r) + 10'd1 == 10'(cfg.max_rows)) ? '0 : head_r + 1'b1;
          held_nxt = (held_r < cfg.max_rows) ? held_r + 9'd1 : held_r;
          open_nxt = 1'b0; wb_nxt = '0; st_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        num_nxt = {(NUMW-F)'(diff_r) * (NUMW-F)'(bins_r - 1'b1), {F{1'b0}}};
        rem_nxt = '0; cnt_nxt = '0; st_nxt = S_DIV;
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle, quotient shifts into num_r
        if (!dt[32]) begin
          rem_nxt = dt[31:0];
          num_nxt = {num_r[NUMW-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[30:0], num_r[NUMW-1]};
          num_nxt = {num_r[NUMW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(NUMW-1)) st_nxt = S_CHK;
      end
      S_CHK: begin
        if (binq >= NUMW'({bins_r, {F{1'b0}}})) begin
          res_nxt = EMPTY_LEVEL; resv_nxt = 1'b0; st_nxt = S_DONE;
        end else begin
          b0_nxt = binq[F +: LEN_W];
          tx_nxt = binq[F-1:0];
          r0_nxt = rowq_r[F +: 9];
          ty_nxt = rowq_r[F-1:0];
          r1_nxt = (rowq_r[F +: 9] + 9'd1 < held_r) ? rowq_r[F +: 9] + 9'd1 : held_r - 9'd1;
          b1_nxt = (binq[F +: LEN_W] + 1'b1 < bins_r) ? binq[F +: LEN_W] + 1'b1
                                                     : bins_r - 1'b1;
          base_nxt = (b10 >= 10'(cfg.max_rows)) ? b10 - 10'(cfg.max_rows) : b10;
          tap_nxt = '0; acc_nxt = '0; emp_nxt = 1'b0;
          st_nxt = S_TAPA;
        end
      end
      S_TAPA: begin
        re = 1'b1; raddr = {RW'(slot), BW'(bx)};
        w_nxt = WW'(wy) * WW'(wx);
        st_nxt = S_TAPB;
      end
      S_TAPB: begin
        if (!cfg.antialias) begin
          res_nxt = rdata_r; resv_nxt = 1'b1; st_nxt = S_DONE;
        end else begin
          if (w_r != '0 && rdata_r == EMPTY_LEVEL) emp_nxt = 1'b1;
          prod_nxt = $signed(PRW'({1'b0, w_r})) * $signed(PRW'($signed(rdata_r)));
          st_nxt = S_TAPC;
        end
      end
      S_TAPC: begin
        acc_nxt = acc_r + prod_r;
        tap_nxt = tap_r + 1'b1;
        st_nxt  = (tap_r == 2'd3) ? S_FIN : S_TAPA;
      end
      S_FIN: begin
        res_nxt  = emp_r ? EMPTY_LEVEL : rnd[2*F +: 16];
        resv_nxt = 1'b1;
        st_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!outv_r || out_pop) begin
          outv_nxt = 1'b1; olev_nxt = res_r; olv_nxt = resv_r; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    if (cfg.clr) begin
      head_nxt = '0; held_nxt = '0; wb_nxt = '0; open_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; head_r <= '0; held_r <= '0; bins_r <= '0;
      wb_r <= '0; open_r <= 1'b0; outv_r <= 1'b0;
    end else begin
      st_r <= st_nxt; head_r <= head_nxt; held_r <= held_nxt; bins_r <= bins_nxt;
      wb_r <= wb_nxt; open_r <= open_nxt; outv_r <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    olev_r <= olev_nxt; olv_r <= olv_nxt; rowq_r <= rowq_nxt; diff_r <= diff_nxt;
    num_r <= num_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt; r0_r <= r0_nxt;
    r1_r <= r1_nxt; b0_r <= b0_nxt; b1_r <= b1_nxt; tx_r <= tx_nxt; ty_r <= ty_nxt;
    base_r <= base_nxt; tap_r <= tap_nxt; w_r <= w_nxt; prod_r <= prod_nxt;
    acc_r <= acc_nxt; emp_r <= emp_nxt; res_r <= res_nxt; resv_r <= resv_nxt;
  end

  `WRBS_ASSERT_ALWAYS(a_open_has_len, !open_r || bins_r != '0)
  `WRBS_ASSERT_ALWAYS(a_wb_in_row, wb_r <= bins_r)
  `WRBS_ASSERT_ALWAYS(a_held_fits, held_r <= cfg.max_rows)
  `WRBS_ASSERT_IMPLY(a_result_holds, outv_r && !out_pop, outv_r && $stable(olev_r))
endmodule
